// ===== sv/rv32s_pkg.sv =====
package rv32s_pkg;

  localparam int MemWords = 1024;
  localparam int MemAw = $clog2(MemWords);
  localparam int MemClearCycles = MemWords;

  localparam logic [6:0] OpReg    = 7'b0110011;
  localparam logic [6:0] OpImm    = 7'b0010011;
  localparam logic [6:0] OpLoad   = 7'b0000011;
  localparam logic [6:0] OpStore  = 7'b0100011;
  localparam logic [6:0] OpBranch = 7'b1100011;
  localparam logic [6:0] OpJump   = 7'b1101111;
  localparam logic [6:0] F7Mul    = 7'b1000000;
  localparam logic [6:0] F7Sub    = 7'b0100000;
  localparam logic [6:0] F7Zero   = 7'b0000000;

  typedef enum logic [3:0] {
    K_ADD, K_SUB, K_AND, K_OR, K_MUL, K_ADDI, K_ANDI, K_ORI,
    K_LW, K_SW, K_BEQ, K_JAL, K_BAD
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [4:0]  rd;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [31:0] imm;
  } uop_t;

endpackage

// ===== sv/rv32s_ram.sv =====
module rv32s_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== sv/rv32s_decode.sv =====
module rv32s_decode (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [31:0]         instr_word,
  output logic                q_valid,
  input  logic                q_ready,
  output rv32s_pkg::uop_t     q_uop
);
  import rv32s_pkg::*;

  // Two-entry queue toward the execute side.
  uop_t       slot [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  uop_t       dec;
  logic [6:0] op;
  logic [2:0] f3;
  logic [6:0] f7;
  logic       push;
  logic       pop;

  assign op = instr_word[6:0];
  assign f3 = instr_word[14:12];
  assign f7 = instr_word[31:25];

  always_comb begin
    dec.rd  = instr_word[11:7];
    dec.rs1 = instr_word[19:15];
    dec.rs2 = instr_word[24:20];
    dec.imm = {{20{instr_word[31]}}, instr_word[31:20]};
    dec.kind = K_BAD;
    case (op)
      OpReg: begin
        if (f7 == F7Zero && f3 == 3'd0) dec.kind = K_ADD;
        else if (f7 == F7Sub && f3 == 3'd0) dec.kind = K_SUB;
        else if (f7 == F7Zero && f3 == 3'd7) dec.kind = K_AND;
        else if (f7 == F7Zero && f3 == 3'd6) dec.kind = K_OR;
        else if (f7 == F7Mul && f3 == 3'd0) dec.kind = K_MUL;
      end
      OpImm: begin
        if (f3 == 3'd0) dec.kind = K_ADDI;
        else if (f3 == 3'd7) dec.kind = K_ANDI;
        else if (f3 == 3'd6) dec.kind = K_ORI;
      end
      OpLoad: begin
        if (f3 == 3'd2) dec.kind = K_LW;
      end
      OpStore: begin
        if (f3 == 3'd2) dec.kind = K_SW;
        dec.imm = {{20{instr_word[31]}}, instr_word[31:25], instr_word[11:7]};
      end
      OpBranch: begin
        if (f3 == 3'd0) dec.kind = K_BEQ;
        dec.imm = {{19{instr_word[31]}}, instr_word[31], instr_word[7],
                   instr_word[30:25], instr_word[11:8], 1'b0};
      end
      OpJump: begin
        dec.kind = K_JAL;
        dec.imm = {12'd0, instr_word[19:12], instr_word[20], instr_word[30:21], 1'b0};
      end
      default: dec.kind = K_BAD;
    endcase
  end

  assign in_ready = (count != 2'd2);
  assign push = in_valid && in_ready;
  assign pop = q_valid && q_ready;
  assign q_valid = (count != 2'd0);
  assign q_uop = slot[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wptr] <= dec;
    end
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  a_count_max: assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue overflow");
  a_full_blocks: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd2) |-> !in_ready) else $error("accept while full");
  a_empty_pop: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd0) |-> !q_valid) else $error("pop from empty queue");
endmodule

// ===== sv/rv32s_exec.sv =====
module rv32s_exec (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  output logic               q_ready,
  input  rv32s_pkg::uop_t    q_uop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        instr_addr,
  output logic [31:0]        next_addr,
  output logic               reg_we,
  output logic [4:0]         dest_reg,
  output logic [31:0]        dest_value,
  output logic               store_done,
  output logic [9:0]         mem_word_addr,
  output logic [31:0]        store_value,
  output logic               taken,
  output logic               illegal
);
  import rv32s_pkg::*;

  // Phase 0 reads registers and addresses the memory; phase 1 retires.
  logic [31:0]      rf [32];
  logic [31:0]      pc;
  logic             busy;
  logic             clearing;
  logic [MemAw:0]   clr_cnt;
  uop_t             u;
  logic [31:0]      a;
  logic [31:0]      b;
  logic [31:0]      ea;
  logic [MemAw-1:0] maddr;
  logic [31:0]      prod;
  logic [31:0]      mem_rdata;
  logic             ram_we;
  logic [MemAw-1:0] ram_waddr;
  logic [31:0]      ram_wdata;
  logic [31:0]      val;
  logic             wr;
  logic             st;
  logic             tk;
  logic             bad;
  logic [31:0]      npc;
  logic             retire;

  assign q_ready = !busy && !clearing;

  always_ff @(posedge clk) begin
    if (q_valid && q_ready) begin
      u <= q_uop;
      a <= (q_uop.rs1 == 5'd0) ? 32'd0 : rf[q_uop.rs1];
      b <= (q_uop.rs2 == 5'd0) ? 32'd0 : rf[q_uop.rs2];
    end
  end

  assign ea = a + u.imm;
  assign maddr = ea[MemAw-1:0];

  // Low 32 bits of the product; one 32x32 multiplier.
  assign prod = a * b;

  // While an instruction waits to retire, the same word is read again so the
  // load data stays valid through a stalled result transfer.
  rv32s_ram #(.Width(32), .Depth(MemWords)) u_dmem (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(busy ? maddr
           : ((q_uop.rs1 == 5'd0) ? q_uop.imm[MemAw-1:0]
              : rf[q_uop.rs1][MemAw-1:0] + q_uop.imm[MemAw-1:0])),
    .rdata(mem_rdata)
  );

  always_comb begin
    val = 32'd0;
    wr = 1'b0;
    st = 1'b0;
    tk = 1'b0;
    bad = 1'b0;
    npc = pc + 32'd4;
    case (u.kind)
      K_ADD:  begin val = a + b; wr = 1'b1; end
      K_SUB:  begin val = a - b; wr = 1'b1; end
      K_AND:  begin val = a & b; wr = 1'b1; end
      K_OR:   begin val = a | b; wr = 1'b1; end
      K_MUL:  begin val = prod; wr = 1'b1; end
      K_ADDI: begin val = ea; wr = 1'b1; end
      K_ANDI: begin val = a & u.imm; wr = 1'b1; end
      K_ORI:  begin val = a | u.imm; wr = 1'b1; end
      K_LW:   begin val = mem_rdata; wr = 1'b1; end
      K_SW:   st = 1'b1;
      K_BEQ: begin
        if (a == b) begin
          tk = 1'b1;
          npc = pc + u.imm;
        end
      end
      K_JAL: begin tk = 1'b1; npc = u.imm; end
      default: begin bad = 1'b1; npc = pc; end
    endcase
    if (u.rd == 5'd0) wr = 1'b0;
    if (!wr) val = 32'd0;
  end

  assign retire = busy && (!out_valid || out_ready);

  always_comb begin
    if (clearing) begin
      ram_we = 1'b1;
      ram_waddr = clr_cnt[MemAw-1:0];
      ram_wdata = 32'd0;
    end else begin
      ram_we = retire && st;
      ram_waddr = maddr;
      ram_wdata = b;
    end
  end

  always_ff @(posedge clk) begin
    if (retire) begin
      instr_addr <= pc;
      next_addr <= npc;
      reg_we <= wr;
      dest_reg <= wr ? u.rd : 5'd0;
      dest_value <= val;
      store_done <= st;
      mem_word_addr <= (u.kind == K_LW || st) ? 10'(maddr) : 10'd0;
      store_value <= st ? b : 32'd0;
      taken <= tk;
      illegal <= bad;
    end
    if (rst) begin
      for (int i = 0; i < 32; i++) rf[i] <= 32'd0;
      pc <= 32'd0;
      busy <= 1'b0;
      out_valid <= 1'b0;
      clearing <= 1'b1;
      clr_cnt <= '0;
    end else begin
      if (clearing) begin
        clr_cnt <= clr_cnt + 1'b1;
        if (clr_cnt == (MemAw+1)'(MemClearCycles - 1)) clearing <= 1'b0;
      end
      if (q_valid && q_ready) busy <= 1'b1;
      else if (retire) busy <= 1'b0;
      if (retire) begin
        out_valid <= 1'b1;
        pc <= npc;
        if (wr) rf[u.rd] <= val;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !q_ready) else $error("took item while busy");
  a_ill_pc: assert property (@(posedge clk) disable iff (rst)
    (out_valid && illegal) |-> (next_addr == instr_addr)) else $error("pc moved on illegal");
  a_x0: assert property (@(posedge clk) disable iff (rst)
    (out_valid && reg_we) |-> (dest_reg != 5'd0)) else $error("x0 written");
  a_clear_idle: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !busy) else $error("work during memory clear");
endmodule

// ===== sv/rv32_subset_instruction_step_top.sv =====
// Channel   Direction  Handshake             Payload
// input     in         in_valid / in_ready   instr_word
// result    out        out_valid / out_ready instr_addr .. illegal (ten fields)
//
// In the execute stage each instruction first reads the register file and
// addresses the synchronous data memory, then retires; execute takes no new
// instruction until the last one has retired.
// After reset the data memory is cleared, one word a cycle, all 1024 words;
// execute takes nothing meanwhile, so at most two input transfers are queued.
// A stalled result transfer holds execute, while decode keeps filling its queue.
module rv32_subset_instruction_step_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] instr_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] instr_addr,
  output logic [31:0] next_addr,
  output logic        reg_we,
  output logic [4:0]  dest_reg,
  output logic [31:0] dest_value,
  output logic        store_done,
  output logic [9:0]  mem_word_addr,
  output logic [31:0] store_value,
  output logic        taken,
  output logic        illegal
);
  import rv32s_pkg::*;

  logic q_valid;
  logic q_ready;
  uop_t q_uop;

  rv32s_decode u_dec (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .instr_word(instr_word), .q_valid(q_valid), .q_ready(q_ready), .q_uop(q_uop)
  );

  rv32s_exec u_exe (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_ready(q_ready), .q_uop(q_uop),
    .out_valid(out_valid), .out_ready(out_ready), .instr_addr(instr_addr),
    .next_addr(next_addr), .reg_we(reg_we), .dest_reg(dest_reg),
    .dest_value(dest_value), .store_done(store_done),
    .mem_word_addr(mem_word_addr), .store_value(store_value), .taken(taken),
    .illegal(illegal)
  );
endmodule
